[src/mhpq_pkg.sv]
`timescale 1ns / 1ps
package mhpq_pkg;

    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = IDX_W + 1;
    localparam int CHD_W    = IDX_W + 2;
    localparam int ID_W     = 16;
    localparam int WT_W     = 32;
    localparam int CMD_W    = 3;
    localparam int ST_W     = 2;
    localparam int ENT_W    = ID_W + WT_W;

    localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_EXTRACT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DECREASE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK     = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE    = 2'd3;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(CAPACITY);

    typedef struct packed {
        logic [ID_W-1:0]        id;
        logic signed [WT_W-1:0] wt;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_ROOT_RD,
        S_ROOT,
        S_POS_RD,
        S_POS,
        S_DEL_RD,
        S_DEL_WR,
        S_LAST_RD,
        S_LAST_GET,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_OUT
    } state_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

endpackage

[src/mhpq_ram.sv]
`timescale 1ns / 1ps
module mhpq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/mhpq_ctrl.sv]
`timescale 1ns / 1ps
module mhpq_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [mhpq_pkg::CMD_W-1:0]   command,
    input  logic [mhpq_pkg::ID_W-1:0]    edge_id,
    input  logic signed [mhpq_pkg::WT_W-1:0] key_weight,
    input  logic [mhpq_pkg::IDX_W-1:0]   position,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [mhpq_pkg::ST_W-1:0]    status,
    output logic [mhpq_pkg::ID_W-1:0]    result_id,
    output logic signed [mhpq_pkg::WT_W-1:0] result_weight,
    output logic [mhpq_pkg::CNT_W-1:0]   entry_count,
    output logic                         is_empty,
    input  logic [mhpq_pkg::CNT_W-1:0]   cap_limit,
    output mhpq_pkg::ram_req_t           ram_req,
    input  mhpq_pkg::entry_t             ram_rdata
);

    import mhpq_pkg::*;

    state_t           state_reg, state_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    entry_t           cur_reg, cur_next;
    entry_t           res_reg, res_next;
    entry_t           left_reg, left_next;
    logic             lsel_reg, lsel_next;
    logic             rok_reg, rok_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [ST_W-1:0]  st_reg, st_next;
    logic             out_valid_reg;
    logic [ST_W-1:0]  out_st_reg;
    entry_t           out_res_reg;
    logic [CNT_W-1:0] out_cnt_reg;

    logic [CNT_W-1:0] limit;
    logic [IDX_W-1:0] parent;
    logic [CHD_W-1:0] lchild, rchild;
    logic             accept, out_free, l_ok, r_ok;
    logic             up_lt, pos_ge, l_lt, r_lt;
    logic signed [WT_W-1:0] best_wt;

    assign limit    = (cap_limit < CAP_RESET) ? cap_limit : CAP_RESET;
    assign accept   = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign parent   = (idx_reg - IDX_W'(1)) >> 1;
    assign lchild   = {1'b0, idx_reg, 1'b1};
    assign rchild   = {1'b0, idx_reg, 1'b0} + CHD_W'(2);
    assign l_ok     = lchild < {1'b0, count_reg};
    assign r_ok     = rchild < {1'b0, count_reg};
    assign best_wt  = lsel_reg ? left_reg.wt : cur_reg.wt;
    // signed weight compares, each used in the states that need it
    assign up_lt    = cur_reg.wt < ram_rdata.wt;
    assign l_lt     = ram_rdata.wt < cur_reg.wt;
    assign r_lt     = ram_rdata.wt < best_wt;
    assign pos_ge   = {1'b0, position} >= count_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (command == CMD_INSERT)
                        state_next = (count_reg >= limit) ? S_OUT : S_UP_RD;
                    else if (command == CMD_EXTRACT || command == CMD_PEEK)
                        state_next = (count_reg == '0) ? S_OUT : S_ROOT_RD;
                    else if (command == CMD_DECREASE || command == CMD_DELETE)
                        state_next = (count_reg == '0 || pos_ge) ? S_OUT : S_POS_RD;
                    else
                        state_next = S_OUT;
                end
            end
            S_UP_RD:    state_next = (idx_reg == '0) ? S_OUT : S_UP_CMP;
            S_UP_CMP:   state_next = up_lt ? S_UP_RD : S_OUT;
            S_ROOT_RD:  state_next = S_ROOT;
            S_ROOT:
            begin
                if (cmd_reg == CMD_PEEK || count_reg == CNT_W'(1))
                    state_next = S_OUT;
                else
                    state_next = S_LAST_RD;
            end
            S_POS_RD:   state_next = S_POS;
            S_POS:
            begin
                if (cmd_reg == CMD_DELETE)
                    state_next = S_DEL_RD;
                else
                    state_next = l_lt ? S_OUT : S_UP_RD;
            end
            S_DEL_RD:
            begin
                if (idx_reg != '0)
                    state_next = S_DEL_WR;
                else
                    state_next = (count_reg == CNT_W'(1)) ? S_OUT : S_LAST_RD;
            end
            S_DEL_WR:   state_next = S_DEL_RD;
            S_LAST_RD:  state_next = S_LAST_GET;
            S_LAST_GET: state_next = S_DN_RDL;
            S_DN_RDL:   state_next = l_ok ? S_DN_RDR : S_OUT;
            S_DN_RDR:   state_next = S_DN_CMP;
            S_DN_CMP:
            begin
                if ((rok_reg && r_lt) || lsel_reg)
                    state_next = S_DN_RDL;
                else
                    state_next = S_OUT;
            end
            S_OUT:      state_next = out_free ? S_IDLE : S_OUT;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and memory port
    always_comb
    begin
        cmd_next   = cmd_reg;
        cur_next   = cur_reg;
        res_next   = res_reg;
        left_next  = left_reg;
        lsel_next  = lsel_reg;
        rok_next   = rok_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        st_next    = st_reg;
        ram_req    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = command;
                    cur_next.id = edge_id;
                    cur_next.wt = key_weight;
                    pos_next    = position;
                    res_next    = '0;
                    st_next     = ST_OK;
                    priority if (command == CMD_INSERT)
                    begin
                        if (count_reg >= limit)
                            st_next = ST_OVERFLOW;
                        else
                        begin
                            idx_next   = count_reg[IDX_W-1:0];
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (command == CMD_EXTRACT || command == CMD_PEEK ||
                             command == CMD_DECREASE || command == CMD_DELETE)
                    begin
                        if (count_reg == '0)
                            st_next = ST_EMPTY;
                        else if ((command == CMD_DECREASE || command == CMD_DELETE) && pos_ge)
                            st_next = ST_RANGE;
                    end
                    else
                        st_next = ST_OK;
                end
            end
            S_UP_RD:
            begin
                if (idx_reg == '0)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = idx_reg;
                    ram_req.wdata = cur_reg;
                end
                ram_req.raddr = parent;
            end
            S_UP_CMP:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = idx_reg;
                if (up_lt)
                begin
                    ram_req.wdata = ram_rdata;
                    idx_next      = parent;
                end
                else
                    ram_req.wdata = cur_reg;
            end
            S_ROOT_RD:  ram_req.raddr = '0;
            S_ROOT:
            begin
                res_next = ram_rdata;
                if (cmd_reg != CMD_PEEK)
                    count_next = count_reg - CNT_W'(1);
            end
            S_POS_RD:   ram_req.raddr = pos_reg;
            S_POS:
            begin
                idx_next = pos_reg;
                if (cmd_reg == CMD_DELETE)
                    res_next = ram_rdata;
                else
                    cur_next.id = ram_rdata.id;
            end
            S_DEL_RD:
            begin
                ram_req.raddr = parent;
                if (idx_reg == '0)
                    count_next = count_reg - CNT_W'(1);
            end
            S_DEL_WR:
            begin
                // ancestors slide down one level toward the deleted slot
                ram_req.we    = 1'b1;
                ram_req.waddr = idx_reg;
                ram_req.wdata = ram_rdata;
                idx_next      = parent;
            end
            S_LAST_RD:  ram_req.raddr = count_reg[IDX_W-1:0];
            S_LAST_GET:
            begin
                cur_next = ram_rdata;
                idx_next = '0;
            end
            S_DN_RDL:
            begin
                ram_req.raddr = lchild[IDX_W-1:0];
                if (!l_ok)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = idx_reg;
                    ram_req.wdata = cur_reg;
                end
            end
            S_DN_RDR:
            begin
                ram_req.raddr = rchild[IDX_W-1:0];
                left_next     = ram_rdata;
                lsel_next     = l_lt;
                rok_next      = r_ok;
            end
            S_DN_CMP:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = idx_reg;
                priority if (rok_reg && r_lt)
                begin
                    ram_req.wdata = ram_rdata;
                    idx_next      = rchild[IDX_W-1:0];
                end
                else if (lsel_reg)
                begin
                    ram_req.wdata = left_reg;
                    idx_next      = lchild[IDX_W-1:0];
                end
                else
                    ram_req.wdata = cur_reg;
            end
            S_OUT:      ram_req = '0;
            default:    ram_req = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        cur_reg  <= cur_next;
        res_reg  <= res_next;
        left_reg <= left_next;
        lsel_reg <= lsel_next;
        rok_reg  <= rok_next;
        idx_reg  <= idx_next;
        pos_reg  <= pos_next;
        st_reg   <= st_next;
        if (state_reg == S_OUT && out_free)
        begin
            out_st_reg  <= st_reg;
            out_res_reg <= res_reg;
            out_cnt_reg <= count_reg;
        end
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = out_st_reg;
    assign result_id     = out_res_reg.id;
    assign result_weight = out_res_reg.wt;
    assign entry_count   = out_cnt_reg;
    assign is_empty      = (out_cnt_reg == '0);

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> ({1'b0, ram_req.waddr} < count_reg))
        else $error("heap write outside held entries");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output state");

endmodule

[src/min_heap_priority_queue_unit.sv]
`timescale 1ns / 1ps
// insert climbs level by level toward the root, decrease_key climbs from the given position,
// extract_min sifts down from the root, delete_key slides the ancestors down to the root
// and then sifts down, peek_min only reads the root
// one command at a time: in_stall stays high until the block is back in idle
// a finished result waits in the output register while the next command is taken
// reset: asynchronous active low, heap empty, capacity_limit 1024, memory not cleared
module min_heap_priority_queue_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [mhpq_pkg::CMD_W-1:0]         command,
    input  logic [mhpq_pkg::ID_W-1:0]          edge_id,
    input  logic signed [mhpq_pkg::WT_W-1:0]   key_weight,
    input  logic [mhpq_pkg::IDX_W-1:0]         position,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [mhpq_pkg::ST_W-1:0]          status,
    output logic [mhpq_pkg::ID_W-1:0]          result_id,
    output logic signed [mhpq_pkg::WT_W-1:0]   result_weight,
    output logic [mhpq_pkg::CNT_W-1:0]         entry_count,
    output logic                               is_empty,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mhpq_pkg::CNT_W-1:0]         cfg_data
);

    import mhpq_pkg::*;

    logic [CNT_W-1:0] cap_reg;
    ram_req_t         ram_req;
    entry_t           ram_rdata;
    logic [ENT_W-1:0] rdata_raw;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (cfg_valid && cfg_ready)
            cap_reg <= cfg_data;
    end

    mhpq_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .edge_id       (edge_id),
        .key_weight    (key_weight),
        .position      (position),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .result_id     (result_id),
        .result_weight (result_weight),
        .entry_count   (entry_count),
        .is_empty      (is_empty),
        .cap_limit     (cap_reg),
        .ram_req       (ram_req),
        .ram_rdata     (ram_rdata)
    );

    mhpq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ENT_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (rdata_raw)
    );

    assign ram_rdata = rdata_raw;

endmodule

[sim/min_heap_priority_queue_unit_tb.sv]
`timescale 1ns / 1ps
module min_heap_priority_queue_unit_tb;
    import mhpq_pkg::*;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [CMD_W-1:0]         command;
    logic [ID_W-1:0]          edge_id;
    logic signed [WT_W-1:0]   key_weight;
    logic [IDX_W-1:0]         position;
    logic                     out_valid;
    logic                     out_stall;
    logic [ST_W-1:0]          status;
    logic [ID_W-1:0]          result_id;
    logic signed [WT_W-1:0]   result_weight;
    logic [CNT_W-1:0]         entry_count;
    logic                     is_empty;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CNT_W-1:0]         cfg_data;

    typedef struct packed {
        logic [ST_W-1:0]        st;
        logic [ID_W-1:0]        id;
        logic signed [WT_W-1:0] wt;
        logic [CNT_W-1:0]       cnt;
        logic                   emp;
    } heap_result_t;

    localparam int CYCLE_LIMIT = 2000000;

    // shadow heap
    logic [ID_W-1:0]        shadow_ids[CAPACITY];
    logic signed [WT_W-1:0] shadow_wts[CAPACITY];
    int                     shadow_count;
    int                     shadow_limit;

    heap_result_t pending_results[$];
    int           mismatch_count;
    int           cycle_count;
    bit           no_idle;

    min_heap_priority_queue_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .edge_id(edge_id), .key_weight(key_weight),
        .position(position),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .result_id(result_id), .result_weight(result_weight),
        .entry_count(entry_count), .is_empty(is_empty),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    task automatic shadow_sift_up(input int start, input logic [ID_W-1:0] id,
                                  input logic signed [WT_W-1:0] wt);
        int i;
        int p;
        i = start;
        while (i != 0)
        begin
            p = (i - 1) / 2;
            if (!(wt < shadow_wts[p]))
                break;
            shadow_ids[i] = shadow_ids[p];
            shadow_wts[i] = shadow_wts[p];
            i = p;
        end
        shadow_ids[i] = id;
        shadow_wts[i] = wt;
    endtask

    task automatic shadow_pop_root();
        int i;
        int l;
        int r;
        int s;
        logic [ID_W-1:0]        tid;
        logic signed [WT_W-1:0] twt;
        shadow_count--;
        if (shadow_count != 0)
        begin
            shadow_ids[0] = shadow_ids[shadow_count];
            shadow_wts[0] = shadow_wts[shadow_count];
            i = 0;
            forever
            begin
                l = 2 * i + 1;
                r = 2 * i + 2;
                s = i;
                if (l < shadow_count && shadow_wts[l] < shadow_wts[s])
                    s = l;
                if (r < shadow_count && shadow_wts[r] < shadow_wts[s])
                    s = r;
                if (s == i)
                    break;
                tid = shadow_ids[i];
                twt = shadow_wts[i];
                shadow_ids[i] = shadow_ids[s];
                shadow_wts[i] = shadow_wts[s];
                shadow_ids[s] = tid;
                shadow_wts[s] = twt;
                i = s;
            end
        end
    endtask

    function automatic int effective_limit();
        return (shadow_limit < CAPACITY) ? shadow_limit : CAPACITY;
    endfunction

    task automatic predict_heap_op(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                                   input logic signed [WT_W-1:0] wt,
                                   input logic [IDX_W-1:0] pos);
        heap_result_t res;
        int i;
        int p;
        res = '0;
        res.st = ST_OK;
        case (cmd)
            CMD_INSERT:
                if (shadow_count >= effective_limit())
                    res.st = ST_OVERFLOW;
                else
                begin
                    shadow_count++;
                    shadow_sift_up(shadow_count - 1, id, wt);
                end
            CMD_EXTRACT, CMD_PEEK:
                if (shadow_count == 0)
                    res.st = ST_EMPTY;
                else
                begin
                    res.id = shadow_ids[0];
                    res.wt = shadow_wts[0];
                    if (cmd == CMD_EXTRACT)
                        shadow_pop_root();
                end
            CMD_DECREASE:
                if (shadow_count == 0)
                    res.st = ST_EMPTY;
                else if (pos >= shadow_count)
                    res.st = ST_RANGE;
                else if (!(shadow_wts[pos] < wt))
                    shadow_sift_up(pos, shadow_ids[pos], wt);
            CMD_DELETE:
                if (shadow_count == 0)
                    res.st = ST_EMPTY;
                else if (pos >= shadow_count)
                    res.st = ST_RANGE;
                else
                begin
                    res.id = shadow_ids[pos];
                    res.wt = shadow_wts[pos];
                    i = pos;
                    while (i != 0)
                    begin
                        p = (i - 1) / 2;
                        shadow_ids[i] = shadow_ids[p];
                        shadow_wts[i] = shadow_wts[p];
                        i = p;
                    end
                    shadow_ids[0] = res.id;
                    shadow_wts[0] = res.wt;
                    shadow_pop_root();
                end
            default:
                ;
        endcase
        res.cnt = shadow_count[CNT_W-1:0];
        res.emp = (shadow_count == 0);
        pending_results.push_back(res);
    endtask

    task automatic idle_burst();
        int n;
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 8);
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_heap_op(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                                input logic signed [WT_W-1:0] wt,
                                input logic [IDX_W-1:0] pos);
        idle_burst();
        in_valid   <= 1'b1;
        command    <= cmd;
        edge_id    <= id;
        key_weight <= wt;
        position   <= pos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_heap_op(cmd, id, wt, pos);
        in_valid <= 1'b0;
        // the block is busy for at least this cycle after a transfer
        @(posedge clk);
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_capacity(input int value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= CNT_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid    <= 1'b0;
        shadow_limit = value;
    endtask

    // position mostly inside the heap, sometimes anywhere
    function automatic logic [IDX_W-1:0] pick_position();
        if (shadow_count > 0 && $urandom_range(0, 9) != 0)
            return IDX_W'($urandom_range(0, shadow_count - 1));
        return IDX_W'($urandom);
    endfunction

    function automatic logic signed [WT_W-1:0] pick_weight();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return WT_W'($urandom_range(0, 15)) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed_edges();
        send_heap_op(CMD_EXTRACT, 0, 0, 0);
        send_heap_op(CMD_PEEK, 0, 0, 0);
        send_heap_op(CMD_DECREASE, 0, 0, 0);
        send_heap_op(CMD_DELETE, 0, 0, 0);
        send_heap_op(CMD_INSERT, 16'hffff, 32'sh7fff_ffff, 0);
        send_heap_op(CMD_INSERT, 16'h0000, 32'sh8000_0000, 10'h3ff);
        send_heap_op(CMD_INSERT, 16'h1234, 5, 0);
        send_heap_op(CMD_INSERT, 16'h1235, 5, 0);
        send_heap_op(CMD_INSERT, 16'h1236, 5, 0);
        send_heap_op(CMD_PEEK, 0, 0, 0);
        send_heap_op(CMD_DECREASE, 0, 32'sh7fff_ffff, 2);
        send_heap_op(CMD_DECREASE, 0, 32'sh8000_0000, 3);
        send_heap_op(CMD_DECREASE, 0, 1, 10'h3ff);
        send_heap_op(CMD_DELETE, 0, 0, 10'h3ff);
        send_heap_op(CMD_DELETE, 0, 0, 4);
        send_heap_op(CMD_DELETE, 0, 0, 0);
        send_heap_op(3'd5, 16'haaaa, 1, 1);
        send_heap_op(3'd6, 0, 0, 0);
        send_heap_op(3'd7, 16'h5555, -1, 10'h2aa);
        repeat (4) send_heap_op(CMD_EXTRACT, 0, 0, 0);
    endtask

    task automatic test_capacity_extremes();
        write_capacity(1);
        send_heap_op(CMD_INSERT, 16'h0001, 7, 0);
        send_heap_op(CMD_INSERT, 16'h0002, 3, 0);
        write_capacity(0);
        send_heap_op(CMD_INSERT, 16'h0003, 1, 0);
        send_heap_op(CMD_EXTRACT, 0, 0, 0);
        write_capacity(2047);
    endtask

    task automatic run_random(input int n, input int max_fill);
        int k;
        int roll;
        logic [CMD_W-1:0] cmd;
        for (k = 0; k < n; k++)
        begin
            roll = $urandom_range(0, 99);
            if (shadow_count < max_fill && roll < 40)
                cmd = CMD_INSERT;
            else if (roll < 55)
                cmd = CMD_EXTRACT;
            else if (roll < 70)
                cmd = CMD_DECREASE;
            else if (roll < 83)
                cmd = CMD_DELETE;
            else if (roll < 96)
                cmd = CMD_PEEK;
            else
                cmd = CMD_W'($urandom_range(0, 7));
            send_heap_op(cmd, ID_W'($urandom), pick_weight(), pick_position());
        end
    endtask

    task automatic test_random_small_limit();
        write_capacity($urandom_range(3, 12));
        run_random(200, 20);
    endtask

    task automatic test_random_default();
        write_capacity(1024);
        run_random(250, 60);
        // wait for every result before going on
        drain_results();
        run_random(100, 60);
    endtask

    task automatic test_fill_to_capacity();
        int k;
        write_capacity(1024);
        for (k = 0; k < 1026; k++)
            send_heap_op(CMD_INSERT, ID_W'($urandom), pick_weight(), 0);
        // lower the limit below count, insert must overflow
        write_capacity(100);
        send_heap_op(CMD_INSERT, 16'h7777, 0, 0);
        no_idle = 1'b1;
        for (k = 0; k < 350; k++)
            send_heap_op(CMD_EXTRACT, 0, 0, 0);
    endtask

    // stall generator and result checker
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 8);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        heap_result_t exp_res;
        heap_result_t got;
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {status, result_id, result_weight, entry_count, is_empty};
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transfer: %p", got);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (got !== exp_res)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected %p actual %p", exp_res, got);
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        command        = '0;
        edge_id        = '0;
        key_weight     = '0;
        position       = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        no_idle        = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        shadow_count   = 0;
        shadow_limit   = 1024;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_edges();
        test_capacity_extremes();
        test_random_small_limit();
        test_random_default();
        test_fill_to_capacity();
        drain_results();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

[min_heap_priority_queue_unit.f]
src/mhpq_pkg.sv
src/mhpq_ram.sv
src/mhpq_ctrl.sv
src/min_heap_priority_queue_unit.sv
sim/min_heap_priority_queue_unit_tb.sv
